### design/hbp_pkg.sv
// Shared types and constants for the Huffman bit packer.
package hbp_pkg;

    localparam int SYM_W       = 8;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // One queued operation for the packing back end
    typedef struct packed {
        logic              flush;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] val;
    } t_op;

endpackage

### design/hbp_front.sv
// Front end: accepts transactions, owns the code table, queues encode/flush operations.
module hbp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_cmd,
    input  logic [hbp_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hbp_pkg::CODE_W-1:0] i_code_value,
    input  logic [hbp_pkg::LEN_W-1:0]  i_code_length,
    output logic                       o_push,
    output hbp_pkg::t_op               o_op,
    input  logic                       i_full
);

    localparam int ENTRY_W = hbp_pkg::CODE_W + hbp_pkg::LEN_W;

    // Code table and per-entry valid bits
    logic [ENTRY_W-1:0]              r_mem [hbp_pkg::TABLE_DEPTH];
    logic [hbp_pkg::TABLE_DEPTH-1:0] r_vbits;
    logic [ENTRY_W-1:0]              r_rd;
    logic                            r_rd_vld;

    // Lookup stage
    logic r_stg_vld;
    logic r_stg_flush;

    logic accept;
    logic is_load;
    logic is_op;
    logic stage_push;
    logic stg_done;
    logic [hbp_pkg::LEN_W-1:0] rd_len;

    assign accept  = i_valid && o_ready;
    assign is_load = (i_cmd == hbp_pkg::CMD_LOAD);
    assign is_op   = (i_cmd == hbp_pkg::CMD_ENCODE) || (i_cmd == hbp_pkg::CMD_FLUSH);

    // Unwritten entries read as length zero
    assign rd_len = r_rd_vld ? r_rd[hbp_pkg::LEN_W-1:0] : '0;

    // Codeless symbols are dropped here
    assign stage_push = r_stg_vld && (r_stg_flush || (rd_len != '0));
    assign stg_done   = stage_push ? !i_full : 1'b1;
    assign o_ready    = !r_stg_vld || stg_done;
    assign o_push     = stage_push && !i_full;

    always_comb begin
        o_op.flush = r_stg_flush;
        o_op.len   = rd_len;
        o_op.val   = r_rd[ENTRY_W-1:hbp_pkg::LEN_W];
    end

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (accept && is_load) begin
            r_mem[i_symbol] <= {i_code_value, i_code_length};
        end
        if (accept) begin
            r_rd     <= r_mem[i_symbol];
            r_rd_vld <= r_vbits[i_symbol];
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
        end else if (accept && is_load) begin
            r_vbits[i_symbol] <= 1'b1;
        end
    end

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld   <= 1'b0;
            r_stg_flush <= 1'b0;
        end else if (accept) begin
            r_stg_vld   <= is_op;
            r_stg_flush <= (i_cmd == hbp_pkg::CMD_FLUSH);
        end else if (stg_done) begin
            r_stg_vld <= 1'b0;
        end
    end

endmodule

### design/hbp_fifo.sv
// Short operation queue between the front end and the packer.
module hbp_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  hbp_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output hbp_pkg::t_op o_op
);

    localparam int CNT_W = hbp_pkg::QPTR_W + 1;

    hbp_pkg::t_op                r_buf [hbp_pkg::QUEUE_DEPTH];
    logic [hbp_pkg::QPTR_W-1:0] r_wptr;
    logic [hbp_pkg::QPTR_W-1:0] r_rptr;
    logic [CNT_W-1:0]           r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_W'(hbp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_buf[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wptr] <= i_op;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### design/hbp_back.sv
// Back end: packs codes into an MSB-aligned bit word, one byte per cycle unless stalled.
module hbp_back #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  hbp_pkg::t_op               i_op,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [hbp_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last
);

    localparam int W  = MAX_CODE_LEN + hbp_pkg::BYTE_W;
    localparam int TW = $clog2(W);
    localparam int CW = $clog2(W + 1);

    // Pending bits sit at the top of r_word, bits below r_total are zero
    logic [W-1:0]  r_word;
    logic [TW-1:0] r_total;
    logic          r_out_vld;
    logic [hbp_pkg::BYTE_W-1:0] r_out_byte;
    logic          r_out_last;

    logic                       emit_en;
    logic [hbp_pkg::LEN_W-1:0]  eff_len;
    logic [W+hbp_pkg::CODE_W-1:0] val_wide;
    logic [W-1:0]               val_m;
    logic [CW-1:0]              sh;
    logic [W-1:0]               ins;

    assign emit_en = (r_total >= TW'(hbp_pkg::BYTE_W)) && (!r_out_vld || i_ready);
    assign o_pop   = !i_empty && (r_total < TW'(hbp_pkg::BYTE_W));

    // Clamp length, mask value, align below pending bits
    always_comb begin
        eff_len  = (i_op.len > hbp_pkg::LEN_W'(MAX_CODE_LEN))
                 ? hbp_pkg::LEN_W'(MAX_CODE_LEN) : i_op.len;
        val_wide = {{W{1'b0}}, i_op.val};
        val_m    = val_wide[W-1:0] & ~({W{1'b1}} << eff_len);
        sh       = CW'(W) - CW'(r_total) - CW'(eff_len);
        ins      = val_m << sh;
    end

    // Bit word and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word    <= '0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_op.flush) begin
                    // Partial byte goes out through the normal byte path
                    r_total <= (r_total != '0) ? TW'(hbp_pkg::BYTE_W) : '0;
                end else begin
                    r_word  <= r_word | ins;
                    r_total <= r_total + TW'(eff_len);
                end
            end else if (emit_en) begin
                r_word  <= r_word << hbp_pkg::BYTE_W;
                r_total <= r_total - TW'(hbp_pkg::BYTE_W);
            end
            if (emit_en) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_out_byte <= r_word[W-1 -: hbp_pkg::BYTE_W];
            r_out_last <= ((r_total >> 3) == TW'(1));
        end
    end

    assign o_valid    = r_out_vld;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

### design/huffman_bit_packer.sv
// Path: encode/flush pass the lookup stage, queue and bit word to the output register.
// Throughput: one byte per cycle from the packer while the output is ready; the packer
// pops an operation only when under a byte is pending; loads never enter the queue.
// Reset: synchronous active-low clears the table valid bits (all lengths read as zero),
// the pending bits, the queue and both handshakes; no clearing pass is needed.
module huffman_bit_packer #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_cmd,
    input  logic [hbp_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hbp_pkg::CODE_W-1:0] i_code_value,
    input  logic [hbp_pkg::LEN_W-1:0]  i_code_length,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [hbp_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last
);

    logic         push;
    logic         full;
    logic         pop;
    logic         empty;
    hbp_pkg::t_op op_in;
    hbp_pkg::t_op op_out;

    // Table lookup and classification
    hbp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_symbol      (i_symbol),
        .i_code_value  (i_code_value),
        .i_code_length (i_code_length),
        .o_push        (push),
        .o_op          (op_in),
        .i_full        (full)
    );

    // Decoupling queue
    hbp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_op    (op_out)
    );

    // Bit packing and byte output
    hbp_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_op       (op_out),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

### design/hbp_checker.sv
// Port-level checks for the Huffman bit packer, bound to the top level.
module hbp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [hbp_pkg::BYTE_W-1:0] o_out_byte,
    input logic                       o_last
);

    // Stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_byte) && $stable(o_last)))
        else $error("output transaction changed while stalled");

    // A non-last byte is always followed by another byte right away
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> o_valid)
        else $error("gap inside a multi-byte burst");

    // Nothing pending out of reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // Input side ready out of reset
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready right after reset");

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_byte (o_out_byte),
    .o_last     (o_last)
);
